/* rtl/tmdc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmdc_pkg: shared types and constants of the modulated delay chorus
// Holds defaults, register indexes, fixed-point constants and the
// controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package tmdc_pkg;

    // parameter defaults
    localparam int DELAY_DEPTH_DEF = 16384;
    localparam int SAMPLE_BITS_DEF = 16;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int GAIN_W      = 16;
    localparam int STEP_W      = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_DRY_GAIN  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WET_GAIN  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TIME_STEP = 2'd2;

    localparam logic [GAIN_W-1:0] DRY_GAIN_RST  = 16'd43690;
    localparam logic [GAIN_W-1:0] WET_GAIN_RST  = 16'd21845;
    localparam logic [STEP_W-1:0] TIME_STEP_RST = 24'd350;

    // time accumulator, Q1.24 seconds
    localparam int FRAC_BITS = 24;
    localparam int ACC_BITS  = 25;
    localparam int TRI_W     = FRAC_BITS + 1;

    // offset = floor(q / 20) through a reciprocal multiply and one correction
    localparam int TRI_DIVISOR  = 20;
    localparam int RECIP_SHIFT  = 22;
    localparam int unsigned RECIP_MULT = (2 ** RECIP_SHIFT) / TRI_DIVISOR;

    // mix rounding
    localparam int MIX_SHIFT = 16;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic tri_mul;
        logic recip_mul;
        logic corr;
        logic addr;
        logic mix_mul;
        logic mix;
    } tmdc_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } tmdc_status_t;

endpackage

/* rtl/tmdc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmdc_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tmdc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/tmdc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmdc_ctrl: sequencing state machine of the chorus
// Steps one sample through offset, memory read and mix, then waits for
// room in the output register.
// ----------------------------------------------------------------------------
module tmdc_ctrl
    import tmdc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  tmdc_status_t status,
    output tmdc_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRI,
        ST_RECIP,
        ST_CORR,
        ST_ADDR,
        ST_MULT,
        ST_MIX
    } state_t;

    state_t state_reg;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_TRI;
                    end
                end
                ST_TRI:   state_reg <= ST_RECIP;
                ST_RECIP: state_reg <= ST_CORR;
                ST_CORR:  state_reg <= ST_ADDR;
                ST_ADDR:  state_reg <= ST_MULT;
                ST_MULT:  state_reg <= ST_MIX;
                ST_MIX: begin
                    if (status.out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // command decode
    always_comb begin
        cmd           = '0;
        cmd.load_in   = (state_reg == ST_IDLE) && s_tvalid;
        cmd.tri_mul   = (state_reg == ST_TRI);
        cmd.recip_mul = (state_reg == ST_RECIP);
        cmd.corr      = (state_reg == ST_CORR);
        cmd.addr      = (state_reg == ST_ADDR);
        cmd.mix_mul   = (state_reg == ST_MULT);
        cmd.mix       = (state_reg == ST_MIX) && status.out_free;
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

/* rtl/tmdc_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmdc_dp: datapath of the chorus
// Config registers, delay line, triangle offset, tap read, mix and
// output register.
// ----------------------------------------------------------------------------
module tmdc_dp
    import tmdc_pkg::*;
#(
    parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output logic [SAMPLE_BITS-1:0] out_sample,
    input  tmdc_cmd_t              cmd,
    output tmdc_status_t           status
);

    localparam int SB  = SAMPLE_BITS;
    localparam int AW  = $clog2(DELAY_DEPTH);
    localparam int DW  = $clog2(DELAY_DEPTH + 1);
    localparam int PW  = TRI_W + DW;
    localparam int RW  = DW + RECIP_SHIFT;
    localparam int EW  = DW + 5;
    localparam int MW  = SB + GAIN_W + 1;
    localparam int SW  = MW + 1;
    localparam int YW  = SW - MIX_SHIFT;
    localparam int MAX_OFF = DELAY_DEPTH / TRI_DIVISOR;

    localparam logic [DW-1:0]     DEPTH_C   = DW'(DELAY_DEPTH);
    localparam logic [TRI_W-1:0]  TRI_ONE   = TRI_W'(1) << FRAC_BITS;
    localparam logic signed [YW-1:0] SAT_MAX = YW'((2 ** (SB - 1)) - 1);
    localparam logic signed [YW-1:0] SAT_MIN = -SAT_MAX - YW'(1);
    localparam logic [SW-1:0]     ROUND_C   = SW'(1) << (MIX_SHIFT - 1);

    logic [GAIN_W-1:0]    dry_gain_reg;
    logic [GAIN_W-1:0]    wet_gain_reg;
    logic [STEP_W-1:0]    time_step_reg;
    logic [ACC_BITS-1:0]  acc_reg;
    logic [AW-1:0]        wp_reg;
    logic                 full_reg;
    logic signed [SB-1:0] x_reg;
    logic [AW-1:0]        wp_old_reg;
    logic [PW-1:0]        prod_reg;
    logic [DW-1:0]        q_reg;
    logic [RW-1:0]        recip_reg;
    logic [AW-1:0]        off_reg;
    logic                 fwd_reg;
    logic                 tap_ok_reg;
    logic signed [MW-1:0] pd_dry_reg;
    logic signed [MW-1:0] pd_wet_reg;
    logic [SB-1:0]        out_data_reg;
    logic                 m_tvalid_reg;

    logic [TRI_W-1:0]     tri_val;
    logic [DW-1:0]        q_val;
    logic [DW-1:0]        est;
    logic [EW-1:0]        rem;
    logic [DW-1:0]        off_full;
    logic [AW:0]          pos_wide;
    logic [AW-1:0]        pos;
    logic [SB-1:0]        rd_data;
    logic signed [SB-1:0] tap;
    logic signed [SW-1:0] sum;
    logic signed [YW-1:0] y_val;
    logic [SB-1:0]        sat_val;
    logic                 wp_wrap;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dry_gain_reg  <= DRY_GAIN_RST;
            wet_gain_reg  <= WET_GAIN_RST;
            time_step_reg <= TIME_STEP_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_DRY_GAIN:  dry_gain_reg  <= cfg_wdata[GAIN_W-1:0];
                REG_WET_GAIN:  wet_gain_reg  <= cfg_wdata[GAIN_W-1:0];
                REG_TIME_STEP: time_step_reg <= cfg_wdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // write pointer, fill flag and time accumulator
    assign wp_wrap = ({1'b0, wp_reg} + (AW+1)'(1)) == (AW+1)'(DELAY_DEPTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            full_reg <= 1'b0;
            acc_reg  <= '0;
        end else if (cmd.load_in) begin
            wp_reg   <= wp_wrap ? '0 : wp_reg + AW'(1);
            full_reg <= full_reg | wp_wrap;
            acc_reg  <= acc_reg + ACC_BITS'(time_step_reg);
        end
    end

    // delay line
    tmdc_ram #(
        .WIDTH (SB),
        .DEPTH (DELAY_DEPTH)
    ) u_delay_ram (
        .aclk    (aclk),
        .wr_en   (cmd.load_in),
        .wr_addr (wp_reg),
        .wr_data (in_sample),
        .rd_en   (cmd.addr),
        .rd_addr (pos),
        .rd_data (rd_data)
    );

    // triangle from the accumulator, mirrored on even seconds
    always_comb begin
        if (acc_reg[FRAC_BITS]) begin
            tri_val = {1'b0, acc_reg[FRAC_BITS-1:0]};
        end else begin
            tri_val = TRI_ONE - {1'b0, acc_reg[FRAC_BITS-1:0]};
        end
    end

    // q = floor(tri * depth / 2^24), then floor(q / 20)
    assign q_val    = prod_reg[FRAC_BITS +: DW];
    assign est      = recip_reg[RECIP_SHIFT +: DW];
    assign rem      = EW'(q_reg) - EW'(est) * EW'(TRI_DIVISOR);
    assign off_full = est + DW'(rem >= EW'(TRI_DIVISOR));

    // tap position behind the sample just written
    assign pos_wide = ({1'b0, wp_old_reg} >= {1'b0, off_reg})
                    ? {1'b0, wp_old_reg} - {1'b0, off_reg}
                    : {1'b0, wp_old_reg} + (AW+1)'(DELAY_DEPTH) - {1'b0, off_reg};
    assign pos      = pos_wide[AW-1:0];

    // tap select: forwarded sample, stored entry or never-written zero
    always_comb begin
        if (fwd_reg) begin
            tap = x_reg;
        end else if (tap_ok_reg) begin
            tap = $signed(rd_data);
        end else begin
            tap = '0;
        end
    end

    // round and saturate the mix
    assign sum   = SW'(pd_dry_reg) + SW'(pd_wet_reg) + $signed(ROUND_C);
    assign y_val = sum[SW-1:MIX_SHIFT];

    always_comb begin
        if (y_val > SAT_MAX) begin
            sat_val = SAT_MAX[SB-1:0];
        end else if (y_val < SAT_MIN) begin
            sat_val = SAT_MIN[SB-1:0];
        end else begin
            sat_val = y_val[SB-1:0];
        end
    end

    // per-sample working registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            x_reg      <= $signed(in_sample);
            wp_old_reg <= wp_reg;
        end
        if (cmd.tri_mul) begin
            prod_reg <= PW'(tri_val) * PW'(DEPTH_C);
        end
        if (cmd.recip_mul) begin
            q_reg     <= q_val;
            recip_reg <= RW'(q_val) * RW'(RECIP_MULT);
        end
        if (cmd.corr) begin
            off_reg <= off_full[AW-1:0];
        end
        if (cmd.addr) begin
            fwd_reg    <= (off_reg == '0);
            tap_ok_reg <= full_reg || (pos <= wp_old_reg);
        end
        if (cmd.mix_mul) begin
            pd_dry_reg <= MW'($signed({1'b0, dry_gain_reg})) * MW'(x_reg);
            pd_wet_reg <= MW'($signed({1'b0, wet_gain_reg})) * MW'(tap);
        end
        if (cmd.mix) begin
            out_data_reg <= sat_val;
        end
    end

    // output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.mix) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign status.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid        = m_tvalid_reg;
    assign out_sample      = out_data_reg;

`ifndef SYNTHESIS
    // tap offset stays within a twentieth of the line
    a_off_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.corr |=> (32'(off_reg) <= 32'(MAX_OFF)))
        else $error("tap offset out of range");

    // reciprocal division leaves a remainder below the divisor
    a_div_exact: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.corr |=> ((32'(q_reg) - 32'(off_reg) * 32'(TRI_DIVISOR))
                      < 32'(TRI_DIVISOR)))
        else $error("offset division off by one");

    // a finished mix never overwrites an untaken beat
    a_mix_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mix |-> (!m_tvalid_reg || m_tready))
        else $error("mix loaded into a full output register");

    // the line fills in order, so a wrapped pointer means a full line
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_in && wp_wrap) |=> (full_reg && wp_reg == '0))
        else $error("fill flag missed the wrap");
`endif

endmodule

/* rtl/triangle_modulated_delay_chorus.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_modulated_delay_chorus: chorus with a triangle-swept delay tap
// Writes each sample into a circular delay line, sweeps a tap with a
// triangle LFO and mixes direct and delayed sample with two gains.
//
//   channel   dir   beat carries
//   s_*       in    one audio sample (sample_in)
//   m_*       out   one mixed sample (sample_out)
//   cfg_*     in    register write: dry_gain, wet_gain, time_step
//
// A sample passes in turn through the accepting step, the offset multiply,
// the reciprocal multiply and its correction, the delay memory read, the
// mix multiply and the output load, one step at a time through the shared
// controller, which accepts no new sample before the output load. m_tvalid
// rises as the mix is loaded into the output register.
// The result waits in the output register while the next sample is taken;
// a result still waiting there holds the next one in its mix step.
// After reset the memory needs no clearing pass: entries not yet written
// read as zero, tracked by the write pointer and a line-full flag.
// ----------------------------------------------------------------------------
module triangle_modulated_delay_chorus
    import tmdc_pkg::*;
#(
    parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_W-1:0]     s_tdata,    // sample_in
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_W-1:0]     m_tdata     // sample_out
);

    tmdc_cmd_t              cmd;
    tmdc_status_t           status;
    logic [SAMPLE_BITS-1:0] out_sample;

    // sequencing
    tmdc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    tmdc_dp #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_sample  (s_tdata[SAMPLE_BITS-1:0]),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .out_sample (out_sample),
        .cmd        (cmd),
        .status     (status)
    );

    // pad result beat to whole bytes
    assign m_tdata = TDATA_W'(out_sample);

endmodule

/* tb/tb_triangle_modulated_delay_chorus.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_modulated_delay_chorus: self-checking bench for the delay chorus
// Drives audio samples in bursts against a stalling receiver, tracks the
// delay line, the triangle sweep and the gain mix in a class of its own, and
// compares every mixed sample with the oldest one it predicted. Gains and
// time step are rewritten between phases, with the extremes among them.
// ----------------------------------------------------------------------------
module tb_triangle_modulated_delay_chorus;
    import tmdc_pkg::*;

    localparam int DEPTH         = DELAY_DEPTH_DEF;
    localparam int SBITS         = SAMPLE_BITS_DEF;
    localparam int TDATA_W       = ((SBITS + 7) / 8) * 8;
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_REPORTS   = 10;
    localparam int HOLD_CYCLES   = 300;

    // index past the last register, writes to it are dropped
    localparam logic [CFG_INDEX_W-1:0] REG_NONE = 2'd3;

    localparam longint MIX_MAX = (longint'(1) << (SBITS - 1)) - 1;
    localparam longint MIX_MIN = -(longint'(1) << (SBITS - 1));

    typedef logic signed [SBITS-1:0] sample_t;

    localparam sample_t S_MAX = sample_t'(MIX_MAX);
    localparam sample_t S_MIN = sample_t'(MIX_MIN);

    // delay line, sweep and mix tracker with the queue of mixed samples due
    class mix_tracker;
        sample_t             line_mem [DEPTH];
        int                  wr_ptr;
        logic [ACC_BITS-1:0] acc;
        logic [GAIN_W-1:0]   dry;
        logic [GAIN_W-1:0]   wet;
        logic [STEP_W-1:0]   step;
        sample_t             due_mix [$];
        int                  mismatches;
        int                  checked;

        function new();
            foreach (line_mem[i]) line_mem[i] = '0;
            wr_ptr     = 0;
            acc        = '0;
            dry        = DRY_GAIN_RST;
            wet        = WET_GAIN_RST;
            step       = TIME_STEP_RST;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_DRY_GAIN:  dry = data[GAIN_W-1:0];
                REG_WET_GAIN:  wet = data[GAIN_W-1:0];
                REG_TIME_STEP: step = data[STEP_W-1:0];
                default: ;
            endcase
        endfunction

        // write the sample, advance the sweep, tap the line and mix
        function sample_t mix_of(sample_t x);
            int                   wp_old;
            int                   pos;
            logic [FRAC_BITS-1:0] frac;
            logic [FRAC_BITS:0]   sweep;
            longint unsigned      tap_off;
            sample_t              tap;
            longint               total;
            longint               y;
            wp_old = wr_ptr;
            line_mem[wp_old] = x;
            wr_ptr = (wp_old + 1 == DEPTH) ? 0 : wp_old + 1;
            acc = acc + ACC_BITS'(step);
            frac = acc[FRAC_BITS-1:0];
            // falling on even seconds, rising on odd ones
            if (acc[FRAC_BITS]) begin
                sweep = {1'b0, frac};
            end else begin
                sweep = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac};
            end
            tap_off = (64'(sweep) * 64'(DEPTH)) / (64'(TRI_DIVISOR) << FRAC_BITS);
            pos = int'((64'(wp_old) + 64'(DEPTH) - (tap_off % 64'(DEPTH))) % 64'(DEPTH));
            tap = line_mem[pos];
            total = longint'(dry) * longint'(x) + longint'(wet) * longint'(tap)
                  + (longint'(1) << (MIX_SHIFT - 1));
            y = total >>> MIX_SHIFT;
            if (y > MIX_MAX) y = MIX_MAX;
            if (y < MIX_MIN) y = MIX_MIN;
            return sample_t'(y);
        endfunction

        function void note_sample(sample_t x);
            due_mix.push_back(mix_of(x));
        endfunction

        function void check_sample(sample_t y);
            sample_t want;
            if (due_mix.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d: unexpected mixed sample %0d", checked, y);
            end else begin
                want = due_mix.pop_front();
                if (want !== y) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result %0d: sample_out expected %0d got %0d",
                                 checked, want, y);
                end
            end
            checked++;
        endfunction

        function int pending();
            return due_mix.size();
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_W-1:0]     s_tdata;    // sample_in
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_W-1:0]     m_tdata;    // sample_out

    mix_tracker sb;
    int         results_seen;

    triangle_modulated_delay_chorus u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 20 ns clock
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // result beats
    initial results_seen = 0;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_sample(sample_t'(m_tdata[SBITS-1:0]));
            results_seen++;
        end
    end

    // receiver: rotating stall patterns, two long hold-offs to back up the input
    initial begin : rx_side
        int cyc;
        int hold_left;
        bit held_first;
        bit held_second;
        m_tready = 1'b0;
        cyc = 0;
        hold_left = 0;
        held_first = 1'b0;
        held_second = 1'b0;
        forever begin
            @(negedge aclk);
            cyc++;
            if (!held_first && results_seen >= 300) begin
                held_first = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (!held_second && results_seen >= 900) begin
                held_second = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case ((cyc / 97) % 4)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) == 1);
                    2:       m_tready <= ($urandom_range(0, 7) != 0);
                    default: m_tready <= ((cyc % 5) != 0);
                endcase
            end
        end
    end

    // mostly full-range noise, some extremes and some quiet passages
    function automatic sample_t pick_sample();
        case ($urandom_range(0, 15))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            3:       return '1;
            4, 5:    return sample_t'(int'($urandom_range(0, 511)) - 256);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // offer one beat and hold it until taken; returns at a falling edge
    task automatic push_sample(input sample_t x);
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(x);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_sample(x);
        @(negedge aclk);
    endtask

    task automatic idle_for(input int n);
        s_tvalid <= 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    // wait until every mixed sample is back and the block has settled
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // random samples in bursts, gaps between bursts unless switched off
    task automatic run_phase(input int n, input bit gaps);
        int burst_left;
        burst_left = $urandom_range(1, 24);
        for (int i = 0; i < n; i++) begin
            push_sample(pick_sample());
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                if (gaps) begin
                    idle_for(($urandom_range(0, 9) == 0) ? 30 : $urandom_range(1, 8));
                end
            end
        end
        drain();
    endtask

    initial begin : stimulus
        int unsigned       need;
        logic [GAIN_W-1:0] g;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        sb = new();
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: field extremes and alternating bit patterns
        push_sample(S_MAX);
        push_sample(S_MIN);
        push_sample('0);
        push_sample('1);
        push_sample(sample_t'(1));
        push_sample(sample_t'(16'h5555));
        push_sample(sample_t'(16'hAAAA));
        drain();

        // full gains written with bits above the gain width, unused index
        write_cfg(REG_DRY_GAIN, 24'hFFFFFF);
        write_cfg(REG_WET_GAIN, 24'hA5FFFF);
        write_cfg(REG_NONE, 24'h123456);

        // steer the sweep to its bottom on an odd second: zero tap offset
        while (sb.acc != {1'b1, {FRAC_BITS{1'b0}}}) begin
            need = ((32'd1 << FRAC_BITS) + (32'd1 << ACC_BITS) - 32'(sb.acc))
                 % (32'd1 << ACC_BITS);
            write_cfg(REG_TIME_STEP, (need > 32'hFFFFFF) ? 24'hFFFFFF : STEP_W'(need));
            push_sample(S_MAX);
            drain();
        end
        write_cfg(REG_TIME_STEP, '0);

        // tap is the sample written in the same beat: mix saturates both ways
        repeat (3) push_sample(S_MAX);
        repeat (3) push_sample(S_MIN);
        push_sample('0);
        push_sample(sample_t'(1));
        drain();

        // largest step, both gains zero
        write_cfg(REG_TIME_STEP, 24'hFFFFFF);
        write_cfg(REG_DRY_GAIN, '0);
        write_cfg(REG_WET_GAIN, '0);
        push_sample(S_MAX);
        push_sample(S_MIN);
        drain();

        // back to reset settings
        write_cfg(REG_DRY_GAIN, CFG_DATA_W'(DRY_GAIN_RST));
        write_cfg(REG_WET_GAIN, CFG_DATA_W'(WET_GAIN_RST));
        write_cfg(REG_TIME_STEP, TIME_STEP_RST);
        run_phase(250, 1'b1);

        // gains splitting unity between dry and wet, faster sweep
        g = GAIN_W'($urandom);
        write_cfg(REG_DRY_GAIN, CFG_DATA_W'(g));
        write_cfg(REG_WET_GAIN, CFG_DATA_W'(16'hFFFF - g));
        write_cfg(REG_TIME_STEP, STEP_W'($urandom_range(1000, 200000)));
        run_phase(250, 1'b1);

        // everything at its top, no idling
        write_cfg(REG_DRY_GAIN, 24'h00FFFF);
        write_cfg(REG_WET_GAIN, 24'h00FFFF);
        write_cfg(REG_TIME_STEP, 24'hFFFFFF);
        run_phase(200, 1'b0);

        // wet only, frozen sweep
        write_cfg(REG_DRY_GAIN, '0);
        write_cfg(REG_WET_GAIN, 24'h00FFFF);
        write_cfg(REG_TIME_STEP, '0);
        run_phase(100, 1'b1);

        // raw random words into every register
        write_cfg(REG_DRY_GAIN, CFG_DATA_W'($urandom));
        write_cfg(REG_WET_GAIN, CFG_DATA_W'($urandom));
        write_cfg(REG_TIME_STEP, CFG_DATA_W'($urandom));
        write_cfg(REG_NONE, CFG_DATA_W'($urandom));
        run_phase(250, 1'b1);

        // slow sweep, random gains
        write_cfg(REG_DRY_GAIN, CFG_DATA_W'($urandom_range(0, 65535)));
        write_cfg(REG_WET_GAIN, CFG_DATA_W'($urandom_range(0, 65535)));
        write_cfg(REG_TIME_STEP, STEP_W'($urandom_range(1, 5000)));
        run_phase(200, 1'b1);

        if (sb.mismatches == 0) begin
            $display("tb_triangle_modulated_delay_chorus: clean");
        end else begin
            $display("tb_triangle_modulated_delay_chorus: errors");
        end
        $finish;
    end

    // run limit
    initial begin
        #10ms;
        $display("tb_triangle_modulated_delay_chorus: errors");
        $finish;
    end

endmodule
